FILE: hw/rtl/congestion_aware_monotone_router_defines.svh
// Assertion macros shared by the router RTL.
`ifndef CONGESTION_AWARE_MONOTONE_ROUTER_DEFINES_SVH
`define CONGESTION_AWARE_MONOTONE_ROUTER_DEFINES_SVH

// An implication checked on every clock edge outside reset.
`define CAMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after another one holds.
`define CAMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/camr_pkg.sv
// ============================================================================
// camr_pkg
// Shared widths and constants of the congestion-aware monotone router.
// ============================================================================
package camr_pkg;
  localparam int MaxGridX  = 32;
  localparam int MaxGridY  = 32;
  localparam int UsageBits = 16;
  localparam int CapBits   = 16;
  localparam int EdgeDepth = MaxGridY * (MaxGridX - 1) + MaxGridX * (MaxGridY - 1);
  localparam int EdgeBits  = 11;
  localparam int CoordBits = 5;
  localparam int SizeBits  = 6;
  localparam int MaxResults = 62;
  localparam int StepBits  = 6;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ROUTE  = 2'd1,
    ACT_RIPUP  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  localparam logic CFG_GRID_X = 1'b0;
  localparam logic CFG_GRID_Y = 1'b1;
endpackage

FILE: hw/rtl/congestion_aware_monotone_router.sv
// ============================================================================
// congestion_aware_monotone_router
// Grid router: per-edge usage and capacity, monotone pin-pair walks.
// ============================================================================
// channel | direction | fields
// in_     | sink      | action, pins, target_edge, capacity_value
// out_    | source    | edge_index, is_vertical, starts_segment, last
// cfg_    | write     | grid_x_size (0), grid_y_size (1)
// After reset a clearing pass sweeps the usage memory, one entry a cycle; no
// item is accepted meanwhile. A load retires in its accept cycle; a rip-up
// keeps the input blocked through its read and write-back states. A route
// sets up, then per edge checks, reads the x edge, reads the y edge, compares,
// rereads the chosen edge and emits; equal pins end at the check, and a walk
// gives at most 62 result beats. Each result beat stalls the walk until taken.
module congestion_aware_monotone_router (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [4:0]                      in_pin_a_x,
  input  logic [4:0]                      in_pin_a_y,
  input  logic [4:0]                      in_pin_b_x,
  input  logic [4:0]                      in_pin_b_y,
  input  logic [10:0]                     in_target_edge,
  input  logic [15:0]                     in_capacity_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [10:0]                     out_edge_index,
  output logic                            out_is_vertical,
  output logic                            out_starts_segment,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [5:0]                      cfg_data
);
  import camr_pkg::*;
  `include "congestion_aware_monotone_router_defines.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RIP_RD, S_RIP_WR, S_SETUP, S_CHECK, S_RD_X, S_RD_Y,
    S_CMP, S_EMIT, S_WAIT
  } state_t;

  state_t state_r;
  logic [UsageBits-1:0] usage_mem [EdgeDepth];
  logic [CapBits-1:0]   cap_mem   [EdgeDepth];

  logic [SizeBits-1:0]  gx_cfg_r, gy_cfg_r, gx_r, gy_r;
  logic [EdgeBits-1:0]  clr_r, te_r, ybase_r;
  logic [CoordBits-1:0] ax_r, ay_r, bx_r, by_r, wx_r, wy_r, sx_r, sy_r;
  logic                 up_r, vert_r, bend_r;
  logic [StepBits-1:0]  n_r;
  logic [EdgeBits-1:0]  xe_r, ye_r, e_r;
  logic [UsageBits-1:0] ud_r, ux_r;
  logic [CapBits-1:0]   cd_r, cx_r;
  logic                 xok_r, yok_r;

  // Shared read address for both memories, also used by rip-up and emit writes; one read a cycle.
  logic [EdgeBits-1:0]  addr;
  logic                 mem_ok;

  always_comb begin
    unique case (state_r)
      S_RD_X:         addr = xe_r;
      S_RD_Y:         addr = ye_r;
      S_WAIT, S_EMIT: addr = e_r;
      default:        addr = te_r;
    endcase
    mem_ok = (addr < EdgeBits'(EdgeDepth));
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      usage_mem[clr_r] <= '0;
    end else if (state_r == S_IDLE && in_valid && in_action == ACT_LOAD &&
                 in_target_edge < EdgeBits'(EdgeDepth)) begin
      cap_mem[in_target_edge] <= in_capacity_value;
    end else if (state_r == S_RIP_WR && mem_ok && ud_r != '0) begin
      usage_mem[addr] <= ud_r - 1'b1;
    end else if (state_r == S_EMIT && out_ready && mem_ok && ud_r != '1) begin
      usage_mem[addr] <= ud_r + 1'b1;
    end
    if (mem_ok) begin
      ud_r <= usage_mem[addr];
      cd_r <= cap_mem[addr];
    end else begin
      ud_r <= '0;
      cd_r <= '0;
    end
  end

  function automatic logic [SizeBits-1:0] clamp_size(input logic [SizeBits-1:0] v,
                                                     input logic [SizeBits-1:0] m);
    if (v < SizeBits'(2)) return SizeBits'(2);
    if (v > m) return m;
    return v;
  endfunction

  function automatic logic [CoordBits-1:0] clamp_coord(input logic [CoordBits-1:0] c,
                                                       input logic [SizeBits-1:0] s);
    logic [SizeBits-1:0] m;
    m = s - 1'b1;
    if ({1'b0, c} > m) return m[CoordBits-1:0];
    return c;
  endfunction

  logic signed [UsageBits+1:0] px, py;
  logic [EdgeBits-1:0] gxm1;
  logic [CoordBits-1:0] nx, ny;

  always_comb begin
    gxm1 = EdgeBits'(gx_r) - 1'b1;
    px = $signed({2'b0, ux_r}) - $signed({2'b0, cx_r});
    py = $signed({2'b0, ud_r}) - $signed({2'b0, cd_r});
    nx = vert_r ? wx_r : wx_r + 1'b1;
    ny = !vert_r ? wy_r : (up_r ? wy_r + 1'b1 : wy_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      gx_cfg_r <= SizeBits'(MaxGridX);
      gy_cfg_r <= SizeBits'(MaxGridY);
      out_valid <= 1'b0;
      in_ready <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_X) gx_cfg_r <= cfg_data;
        else gy_cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == EdgeBits'(EdgeDepth - 1)) begin
            state_r  <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            te_r <= in_target_edge;
            gx_r <= clamp_size(gx_cfg_r, SizeBits'(MaxGridX));
            gy_r <= clamp_size(gy_cfg_r, SizeBits'(MaxGridY));
            ax_r <= in_pin_a_x;
            ay_r <= in_pin_a_y;
            bx_r <= in_pin_b_x;
            by_r <= in_pin_b_y;
            if (in_action == ACT_RIPUP) begin
              state_r <= S_RIP_RD; in_ready <= 1'b0;
            end else if (in_action == ACT_ROUTE) begin
              state_r <= S_SETUP; in_ready <= 1'b0;
            end
          end
        end
        S_RIP_RD: state_r <= S_RIP_WR;  // ud_r loads here
        S_RIP_WR: begin
          state_r <= S_IDLE; in_ready <= 1'b1;
        end
        S_SETUP: begin
          // Clamp, order pins left to right, and seed the walk.
          logic [CoordBits-1:0] a_x, a_y, b_x, b_y;
          a_x = clamp_coord(ax_r, gx_r); a_y = clamp_coord(ay_r, gy_r);
          b_x = clamp_coord(bx_r, gx_r); b_y = clamp_coord(by_r, gy_r);
          if (a_x > b_x || (a_x == b_x && a_y > b_y)) begin
            wx_r <= b_x; wy_r <= b_y; bx_r <= a_x; by_r <= a_y;
            sx_r <= b_x; sy_r <= b_y; up_r <= (a_y >= b_y);
          end else begin
            wx_r <= a_x; wy_r <= a_y; bx_r <= b_x; by_r <= b_y;
            sx_r <= a_x; sy_r <= a_y; up_r <= (b_y >= a_y);
          end
          ybase_r <= EdgeBits'(gy_r * gxm1);
          n_r <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          xe_r <= EdgeBits'(wx_r) + EdgeBits'(wy_r * gxm1);
          ye_r <= ybase_r + EdgeBits'(wx_r) +
                  EdgeBits'(up_r ? wy_r : wy_r - 1'b1) * EdgeBits'(gx_r);
          xok_r <= (wx_r == bx_r);
          yok_r <= (wy_r == by_r);
          if (wx_r == bx_r && wy_r == by_r) begin
            state_r <= S_IDLE; in_ready <= 1'b1;
          end else begin
            state_r <= S_RD_X;
          end
        end
        S_RD_X: state_r <= S_RD_Y;
        S_RD_Y: begin
          ux_r <= ud_r; cx_r <= cd_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          // ud_r/cd_r now hold the y edge.
          logic v;
          if (xok_r) v = 1'b1;
          else if (yok_r) v = 1'b0;
          else v = !(px < py);
          vert_r <= v;
          e_r <= v ? ye_r : xe_r;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          // Reread the chosen edge's usage for the increment.
          bend_r <= (nx != sx_r) && (ny != sy_r);
          state_r <= S_EMIT;
          out_valid <= 1'b1;
          out_edge_index <= e_r;
          out_is_vertical <= vert_r;
          out_starts_segment <= (nx != sx_r) && (ny != sy_r);
          out_last <= ((nx == bx_r) && (ny == by_r)) ||
                      (n_r == StepBits'(MaxResults - 1));
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (bend_r) begin
              sx_r <= wx_r; sy_r <= wy_r;
            end
            wx_r <= nx; wy_r <= ny;
            n_r <= n_r + 1'b1;
            if (out_last) begin
              state_r <= S_IDLE; in_ready <= 1'b1;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CAMR_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_valid, !in_ready,
                    "accept while emitting")
  `CAMR_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_edge_index), "result dropped")
  `CAMR_ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_r == S_CLEAR,
                    !in_ready && !out_valid, "activity during clear")
endmodule

FILE: bench/camr_checker.sv
// ----------------------------------------------------------------------------
// camr_checker
// Watches the router's channels, computes the edges each pin pair should take
// and compares every result beat against the oldest predicted edge.
// ----------------------------------------------------------------------------
module camr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_pin_a_x,
  input  logic [4:0]  in_pin_a_y,
  input  logic [4:0]  in_pin_b_x,
  input  logic [4:0]  in_pin_b_y,
  input  logic [10:0] in_target_edge,
  input  logic [15:0] in_capacity_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] out_edge_index,
  input  logic        out_is_vertical,
  input  logic        out_starts_segment,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  output int          fail_count,
  output int          pending_edges
);
  import camr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] edge_idx;
    logic        vert;
    logic        bend;
    logic        last;
  } path_edge_t;

  logic [UsageBits-1:0] usage [EdgeDepth];
  logic [CapBits-1:0]   cap [EdgeDepth];
  logic [5:0]           size_x, size_y;
  path_edge_t           path_q[$];
  int                   errors;

  assign fail_count    = errors;
  assign pending_edges = path_q.size();

  function automatic int eff_size(logic [5:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int pin_coord(logic [4:0] v, int sz);
    return (v > sz - 1) ? sz - 1 : v;
  endfunction

  function automatic int congestion(int e);
    return int'(usage[e]) - int'(cap[e]);
  endfunction

  task automatic predict_route(logic [4:0] pax, logic [4:0] pay, logic [4:0] pbx,
                               logic [4:0] pby);
    int gx, gy, ax, ay, bx, by, t, ybase, wx, wy, sx, sy, nx, ny, xe, ye, e, n;
    bit up, vert, bend;
    path_edge_t pe;
    gx = eff_size(size_x, MaxGridX);
    gy = eff_size(size_y, MaxGridY);
    ax = pin_coord(pax, gx);
    ay = pin_coord(pay, gy);
    bx = pin_coord(pbx, gx);
    by = pin_coord(pby, gy);
    ybase = gy * (gx - 1);
    if (ax > bx || (ax == bx && ay > by)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    up = by >= ay;
    wx = ax;
    wy = ay;
    sx = ax;
    sy = ay;
    n = 0;
    while ((wx != bx || wy != by) && n < MaxResults) begin
      xe = wx + wy * (gx - 1);
      ye = ybase + wx + (up ? wy : wy - 1) * gx;
      if (wx == bx) vert = 1;
      else if (wy == by) vert = 0;
      else vert = !(congestion(xe) < congestion(ye));
      nx = wx;
      ny = wy;
      if (vert) ny = up ? wy + 1 : wy - 1;
      else nx = wx + 1;
      e = vert ? ye : xe;
      bend = (nx != sx) && (ny != sy);
      if (bend) begin
        sx = wx;
        sy = wy;
      end
      pe.edge_idx = e[10:0];
      pe.vert = vert;
      pe.bend = bend;
      pe.last = (nx == bx) && (ny == by);
      path_q.insert(path_q.size(), pe);
      if (usage[e] != {UsageBits{1'b1}}) usage[e] = usage[e] + 1'b1;
      wx = nx;
      wy = ny;
      n++;
    end
  endtask

  always @(posedge clk) begin
    path_edge_t want;
    if (!rst_n) begin
      foreach (usage[i]) usage[i] = '0;
      size_x = 6'd32;
      size_y = 6'd32;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_X) size_x = cfg_data;
        else size_y = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (action_t'(in_action))
          ACT_LOAD: if (in_target_edge < EdgeDepth) cap[in_target_edge] = in_capacity_value;
          ACT_RIPUP: begin
            if (in_target_edge < EdgeDepth && usage[in_target_edge] != 0)
              usage[in_target_edge] = usage[in_target_edge] - 1'b1;
          end
          ACT_ROUTE: predict_route(in_pin_a_x, in_pin_a_y, in_pin_b_x, in_pin_b_y);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (path_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected beat edge=%0d vert=%0b bend=%0b last=%0b", $realtime,
                     out_edge_index, out_is_vertical, out_starts_segment, out_last);
        end else begin
          want = path_q.pop_front();
          if (want.edge_idx !== out_edge_index || want.vert !== out_is_vertical ||
              want.bend !== out_starts_segment || want.last !== out_last) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp edge=%0d vert=%0b bend=%0b last=%0b, ",
                        "got edge=%0d vert=%0b bend=%0b last=%0b"},
                       $realtime, want.edge_idx, want.vert, want.bend, want.last,
                       out_edge_index, out_is_vertical, out_starts_segment, out_last);
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives load, route and rip-up beats into the router over several grid
// sizes and idle patterns; the checker predicts and compares every edge.
// ----------------------------------------------------------------------------
module tb;
  import camr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Edge count of the largest grid used below (9 by 9); every other grid's
  // edges are a prefix of this range.
  localparam int PreloadEdges = 144;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_UNUSED;
  logic [4:0]  in_pin_a_x = '0, in_pin_a_y = '0, in_pin_b_x = '0, in_pin_b_y = '0;
  logic [10:0] in_target_edge = '0;
  logic [15:0] in_capacity_value = '0;
  logic        out_valid, out_ready = 0;
  logic [10:0] out_edge_index;
  logic        out_is_vertical, out_starts_segment, out_last;
  logic        cfg_we = 0;
  logic        cfg_index = CFG_GRID_X;
  logic [5:0]  cfg_data = '0;
  int          fail_count, pending_edges;
  int          send_idle_pct = 29, recv_stall_pct = 45;
  int          quiet_cycles = 0;

  congestion_aware_monotone_router dut (.*);
  camr_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Any handshake resets the watchdog; the post-reset clearing pass fits easily.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, logic [4:0] ax, logic [4:0] ay, logic [4:0] bx,
                           logic [4:0] by, logic [10:0] te, logic [15:0] cv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_pin_a_x <= ax;
    in_pin_a_y <= ay;
    in_pin_b_x <= bx;
    in_pin_b_y <= by;
    in_target_edge <= te;
    in_capacity_value <= cv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_and_configure(logic [5:0] sx, logic [5:0] sy);
    in_valid <= 0;
    @(posedge clk);
    while (pending_edges != 0) @(posedge clk);
    // Loads and rip-ups produce no beat, so allow them time to retire.
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_GRID_X;
    cfg_data <= sx;
    @(posedge clk);
    cfg_index <= CFG_GRID_Y;
    cfg_data <= sy;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_beat();
    int pick;
    logic [15:0] cv;
    pick = $urandom_range(0, 99);
    cv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    if (pick < 72)
      send_beat(ACT_ROUTE, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                11'($urandom), 16'($urandom));
    else if (pick < 82)
      send_beat(ACT_LOAD, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                11'($urandom), cv);
    else if (pick < 96)
      send_beat(ACT_RIPUP, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                11'($urandom_range(0, EdgeDepth - 1)), 16'($urandom));
    else
      send_beat(ACT_UNUSED, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                11'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [5:0] gsx [6];
    logic [5:0] gsy [6];
    gsx = '{6'd9, 6'd0, 6'd63, 6'd5, 6'd2, 6'd17};
    gsy = '{6'd9, 6'd1, 6'd2, 6'd9, 6'd63, 6'd3};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    drain_and_configure(6'd9, 6'd9);

    // Every capacity in use gets a value first, so no walk compares an unset one.
    for (int e = 0; e < PreloadEdges; e++)
      send_beat(ACT_LOAD, '0, '0, '0, '0, 11'(e), 16'($urandom_range(0, 4)));

    // Directed: corners, both directions, equal pins, ignored beats, rip-up at zero.
    send_beat(ACT_ROUTE, 5'd0, 5'd0, 5'd31, 5'd31, '0, '0);
    send_beat(ACT_ROUTE, 5'd31, 5'd0, 5'd0, 5'd31, '0, '0);
    send_beat(ACT_ROUTE, 5'd0, 5'd31, 5'd31, 5'd0, '0, '0);
    send_beat(ACT_ROUTE, 5'd7, 5'd7, 5'd7, 5'd7, '0, '0);
    send_beat(ACT_ROUTE, 5'd3, 5'd20, 5'd3, 5'd4, '0, '0);
    send_beat(ACT_ROUTE, 5'd2, 5'd9, 5'd30, 5'd9, '0, '0);
    send_beat(ACT_LOAD, '0, '0, '0, '0, 11'd2047, 16'hFFFF);
    send_beat(ACT_LOAD, '0, '0, '0, '0, 11'd0, 16'hFFFF);
    send_beat(ACT_LOAD, '0, '0, '0, '0, 11'd1983, 16'd0);
    send_beat(ACT_RIPUP, '0, '0, '0, '0, 11'd2047, '0);
    send_beat(ACT_RIPUP, '0, '0, '0, '0, 11'd1983, '0);
    send_beat(ACT_RIPUP, '0, '0, '0, '0, 11'd1983, '0);
    send_beat(ACT_RIPUP, '0, '0, '0, '0, 11'd0, '0);
    send_beat(ACT_UNUSED, 5'd31, 5'd31, 5'd0, 5'd0, 11'd5, 16'd9);
    send_beat(ACT_ROUTE, 5'd0, 5'd0, 5'd1, 5'd1, '0, '0);
    send_beat(ACT_ROUTE, 5'd31, 5'd31, 5'd0, 5'd0, '0, '0);

    for (int p = 0; p < 6; p++) begin
      drain_and_configure(gsx[p], gsy[p]);
      case (p / 2)
        0: begin send_idle_pct = 29; recv_stall_pct = 45; end
        1: begin send_idle_pct = 45; recv_stall_pct = 29; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // Pins beyond a small grid clamp to its edge.
      if (p == 1) send_beat(ACT_ROUTE, 5'd31, 5'd0, 5'd0, 5'd31, '0, '0);
      repeat (43) random_beat();
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending_edges != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
